[src/ssc_pkg.sv]
`default_nettype none
package ssc_pkg;

    // Coordinate format: signed Q11.8 in CW bits.
    localparam int CW       = 20;
    localparam int RW       = CW - 1;        // unscaled and scaled radius
    localparam int SCW      = 16;            // one scale component, Q8.8
    localparam int SCALE_FB = 8;
    localparam int OFFW     = 3 * CW;        // packed vector
    localparam int SCLW     = 3 * SCW;       // packed scale
    localparam int CENW     = CW + 1;        // world center
    localparam int MW       = CW + 2;        // full magnitude of a center difference
    localparam int SQW      = 2 * CW;        // squared distance on a hit
    localparam int REMW     = CW + 2;        // square root partial remainder
    localparam int DISTW    = CW + 1;        // rounded distance
    localparam int NFB      = 14;            // normal fraction bits
    localparam int NW       = 16;            // normal width
    localparam int QW       = NFB + 1;       // normal magnitude quotient bits
    localparam int NUMW     = CW + NFB + 1;  // dividend of the normal
    localparam int PRW      = QW + RW;       // normal times radius
    localparam int OAW      = PRW + 1 - NFB; // rounded offset magnitude
    localparam int EW       = CW + 3;        // deep point before saturation

    localparam logic [RW-1:0] RMAX = {RW{1'b1}};

    typedef struct packed {
        logic [OFFW-1:0] a_offset;
        logic [OFFW-1:0] a_position;
        logic [SCLW-1:0] a_scale;
        logic [RW-1:0]   radius_a;
        logic [OFFW-1:0] b_offset;
        logic [OFFW-1:0] b_position;
        logic [SCLW-1:0] b_scale;
        logic [RW-1:0]   radius_b;
    } pair_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] deep_a_x;
        logic signed [CW-1:0] deep_a_y;
        logic signed [CW-1:0] deep_a_z;
        logic signed [CW-1:0] deep_b_x;
        logic signed [CW-1:0] deep_b_y;
        logic signed [CW-1:0] deep_b_z;
        logic signed [NW-1:0] normal_x;
        logic signed [NW-1:0] normal_y;
        logic signed [NW-1:0] normal_z;
        logic [CW-1:0]        penetration;
    } contact_t;

    // Per-pair context that travels alongside the arithmetic cells.
    typedef struct packed {
        logic                      hit;
        logic [2:0][CENW-1:0]      ac;
        logic [2:0][CENW-1:0]      bc;
        logic [2:0]                dneg;
        logic [2:0][CW-1:0]        mag;
        logic [RW-1:0]             ra;
        logic [RW-1:0]             rb;
        logic [CW-1:0]             rsum;
    } ctx_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        hi = EW'((1 << (CW - 1)) - 1);
        lo = -hi - EW'(1);
        if (v > hi) begin
            return hi[CW-1:0];
        end
        if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

[src/ssc_stream_if.sv]
`default_nettype none
interface ssc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/ssc_sqrt_cell.sv]
`default_nettype none
// One digit of a restoring square root; the pair context rides along.
module ssc_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       v_in,
    input  ssc_pkg::ctx_t              ctx_in,
    input  logic [ssc_pkg::SQW-1:0]    rad_in,
    input  logic [ssc_pkg::REMW-1:0]   rem_in,
    input  logic [ssc_pkg::CW-1:0]     root_in,
    output logic                       v_out,
    output ssc_pkg::ctx_t              ctx_out,
    output logic [ssc_pkg::SQW-1:0]    rad_out,
    output logic [ssc_pkg::REMW-1:0]   rem_out,
    output logic [ssc_pkg::CW-1:0]     root_out
);
    logic                     v_reg;
    ssc_pkg::ctx_t            ctx_reg;
    logic [ssc_pkg::SQW-1:0]  rad_reg, rad_next;
    logic [ssc_pkg::REMW-1:0] rem_reg, rem_next, t, trial;
    logic [ssc_pkg::CW-1:0]   root_reg, root_next;

    always_comb
    begin
        t        = {rem_in[ssc_pkg::REMW-3:0], rad_in[ssc_pkg::SQW-1 -: 2]};
        trial    = {root_in, 2'b01};
        rad_next = {rad_in[ssc_pkg::SQW-3:0], 2'b00};
        if (t >= trial)
        begin
            rem_next  = t - trial;
            root_next = {root_in[ssc_pkg::CW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = t;
            root_next = {root_in[ssc_pkg::CW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg  <= ctx_in;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign v_out    = v_reg;
    assign ctx_out  = ctx_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule
`default_nettype wire

[src/ssc_div_cell.sv]
`default_nettype none
// One quotient bit of a restoring division, for all three normal lanes.
module ssc_div_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                v_in,
    input  ssc_pkg::ctx_t                       ctx_in,
    input  logic [ssc_pkg::DISTW-1:0]           den_in,
    input  logic [2:0][ssc_pkg::DISTW-1:0]      rem_in,
    input  logic [2:0][ssc_pkg::QW-1:0]         num_in,
    input  logic [2:0][ssc_pkg::QW-1:0]         q_in,
    output logic                                v_out,
    output ssc_pkg::ctx_t                       ctx_out,
    output logic [ssc_pkg::DISTW-1:0]           den_out,
    output logic [2:0][ssc_pkg::DISTW-1:0]      rem_out,
    output logic [2:0][ssc_pkg::QW-1:0]         num_out,
    output logic [2:0][ssc_pkg::QW-1:0]         q_out
);
    logic                                v_reg;
    ssc_pkg::ctx_t                       ctx_reg;
    logic [ssc_pkg::DISTW-1:0]           den_reg;
    logic [2:0][ssc_pkg::DISTW-1:0]      rem_reg, rem_next;
    logic [2:0][ssc_pkg::QW-1:0]         num_reg, num_next, q_reg, q_next;
    logic [2:0][ssc_pkg::DISTW:0]        t;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t[k]        = {rem_in[k], num_in[k][ssc_pkg::QW-1]};
            num_next[k] = {num_in[k][ssc_pkg::QW-2:0], 1'b0};
            if (t[k] >= {1'b0, den_in})
            begin
                rem_next[k] = ssc_pkg::DISTW'(t[k] - {1'b0, den_in});
                q_next[k]   = {q_in[k][ssc_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[k][ssc_pkg::DISTW-1:0];
                q_next[k]   = {q_in[k][ssc_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    assign v_out   = v_reg;
    assign ctx_out = ctx_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign q_out   = q_reg;
endmodule
`default_nettype wire

[src/sphere_sphere_contact.sv]
`default_nettype none
// Channel   Dir  Payload                Meaning
// pair      in   ssc_pkg::pair_t        two spheres: offsets, positions, scales, radii
// contact   out  ssc_pkg::contact_t     hit flag, deep points, normal, penetration
//
// One sphere pair is accepted per clock while the skid slot is empty; results
// leave in order, one per pair. The pipeline is four front stages, one cell
// per root bit (20), a rounding stage, one cell per normal quotient bit (15),
// a multiply stage and the output register; the cell rows set its depth.
// Reset clears only valid flags; no payload register is reset.
// A skid register behind the output lets the pipeline advance while a result
// waits; the whole pipeline stalls only when both output registers are full.
module sphere_sphere_contact (
    input  logic              clk,
    input  logic              rst_n,
    ssc_stream_if.sink        pair,
    ssc_stream_if.source      contact
);
    localparam int CW    = ssc_pkg::CW;
    localparam int RW    = ssc_pkg::RW;
    localparam int SCW   = ssc_pkg::SCW;
    localparam int CENW  = ssc_pkg::CENW;
    localparam int MW    = ssc_pkg::MW;
    localparam int SQW   = ssc_pkg::SQW;
    localparam int REMW  = ssc_pkg::REMW;
    localparam int DISTW = ssc_pkg::DISTW;
    localparam int NFB   = ssc_pkg::NFB;
    localparam int NW    = ssc_pkg::NW;
    localparam int QW    = ssc_pkg::QW;
    localparam int NUMW  = ssc_pkg::NUMW;
    localparam int PRW   = ssc_pkg::PRW;
    localparam int OAW   = ssc_pkg::OAW;
    localparam int EW    = ssc_pkg::EW;

    // Global advance: every stage moves together unless the skid slot is full.
    logic en;

    // Stage 1: world centers, differences and raw radius products.
    logic                    v1_reg;
    logic [2:0][CENW-1:0]    ac1_reg, bc1_reg, ac1_next, bc1_next;
    logic [2:0]              dneg1_reg, dneg1_next;
    logic [2:0][MW-1:0]      mag1_reg, mag1_next;
    logic [RW+SCW-1:0]       pa1_reg, pb1_reg, pa1_next, pb1_next;
    logic signed [MW-1:0]    d1 [3];
    logic [SCW-1:0]          sa_max, sb_max;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ac1_next[k] = CENW'($signed({pair.data.a_offset[k*CW+CW-1],
                                           pair.data.a_offset[k*CW +: CW]})
                             + $signed({pair.data.a_position[k*CW+CW-1],
                                        pair.data.a_position[k*CW +: CW]}));
            bc1_next[k] = CENW'($signed({pair.data.b_offset[k*CW+CW-1],
                                           pair.data.b_offset[k*CW +: CW]})
                             + $signed({pair.data.b_position[k*CW+CW-1],
                                        pair.data.b_position[k*CW +: CW]}));
            d1[k] = $signed({bc1_next[k][CENW-1], bc1_next[k]})
                  - $signed({ac1_next[k][CENW-1], ac1_next[k]});
            dneg1_next[k] = d1[k][MW-1];
            mag1_next[k]  = d1[k][MW-1] ? MW'(-d1[k]) : MW'(d1[k]);
        end
        sa_max = pair.data.a_scale[SCW-1:0];
        if (pair.data.a_scale[SCW +: SCW] > sa_max)
        begin
            sa_max = pair.data.a_scale[SCW +: SCW];
        end
        if (pair.data.a_scale[2*SCW +: SCW] > sa_max)
        begin
            sa_max = pair.data.a_scale[2*SCW +: SCW];
        end
        sb_max = pair.data.b_scale[SCW-1:0];
        if (pair.data.b_scale[SCW +: SCW] > sb_max)
        begin
            sb_max = pair.data.b_scale[SCW +: SCW];
        end
        if (pair.data.b_scale[2*SCW +: SCW] > sb_max)
        begin
            sb_max = pair.data.b_scale[2*SCW +: SCW];
        end
        pa1_next = (RW+SCW)'(pair.data.radius_a) * (RW+SCW)'(sa_max);
        pb1_next = (RW+SCW)'(pair.data.radius_b) * (RW+SCW)'(sb_max);
    end

    // Stage 2: saturated radii, radius sum and the per-axis early reject.
    logic          v2_reg;
    ssc_pkg::ctx_t ctx2_reg, ctx2_next;
    logic          far2_reg, far2_next;
    logic [RW+SCW-1-ssc_pkg::SCALE_FB:0] sha, shb;

    always_comb
    begin
        sha = pa1_reg[RW+SCW-1:ssc_pkg::SCALE_FB];
        shb = pb1_reg[RW+SCW-1:ssc_pkg::SCALE_FB];
        ctx2_next.hit  = 1'b0;
        ctx2_next.ac   = ac1_reg;
        ctx2_next.bc   = bc1_reg;
        ctx2_next.dneg = dneg1_reg;
        ctx2_next.ra   = (sha > (RW+SCW-ssc_pkg::SCALE_FB)'(ssc_pkg::RMAX))
                         ? ssc_pkg::RMAX : sha[RW-1:0];
        ctx2_next.rb   = (shb > (RW+SCW-ssc_pkg::SCALE_FB)'(ssc_pkg::RMAX))
                         ? ssc_pkg::RMAX : shb[RW-1:0];
        ctx2_next.rsum = CW'(ctx2_next.ra) + CW'(ctx2_next.rb);
        far2_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ctx2_next.mag[k] = mag1_reg[k][CW-1:0];
            if (mag1_reg[k] > MW'(ctx2_next.rsum))
            begin
                far2_next = 1'b1;
            end
        end
    end

    // Stage 3: squares of the differences and of the radius sum.
    logic               v3_reg;
    ssc_pkg::ctx_t      ctx3_reg;
    logic               far3_reg;
    logic [2:0][SQW-1:0] sq3_reg, sq3_next;
    logic [SQW-1:0]     rsq3_reg, rsq3_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq3_next[k] = SQW'(ctx2_reg.mag[k]) * SQW'(ctx2_reg.mag[k]);
        end
        rsq3_next = SQW'(ctx2_reg.rsum) * SQW'(ctx2_reg.rsum);
    end

    // Stage 4: squared distance and the hit decision. A miss feeds zeros on.
    logic           v4_reg;
    ssc_pkg::ctx_t  ctx4_reg, ctx4_next;
    logic [SQW-1:0] rad4_reg, rad4_next;
    logic [SQW+1:0] dist2;

    always_comb
    begin
        dist2 = (SQW+2)'(sq3_reg[0]) + (SQW+2)'(sq3_reg[1]) + (SQW+2)'(sq3_reg[2]);
        ctx4_next     = ctx3_reg;
        ctx4_next.hit = !far3_reg && (dist2 != '0) && (dist2 <= (SQW+2)'(rsq3_reg));
        rad4_next     = ctx4_next.hit ? dist2[SQW-1:0] : '0;
    end

    // Square root: one cell per result bit.
    logic          sv   [CW+1];
    ssc_pkg::ctx_t sctx [CW+1];
    logic [SQW-1:0]  srad  [CW+1];
    logic [REMW-1:0] srem  [CW+1];
    logic [CW-1:0]   sroot [CW+1];

    assign sv[0]    = v4_reg;
    assign sctx[0]  = ctx4_reg;
    assign srad[0]  = rad4_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;

    for (genvar i = 0; i < CW; i++)
    begin : g_sqrt
        ssc_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sv[i]),
            .ctx_in   (sctx[i]),
            .rad_in   (srad[i]),
            .rem_in   (srem[i]),
            .root_in  (sroot[i]),
            .v_out    (sv[i+1]),
            .ctx_out  (sctx[i+1]),
            .rad_out  (srad[i+1]),
            .rem_out  (srem[i+1]),
            .root_out (sroot[i+1])
        );
    end

    // Rounding stage: nearest distance and the normal dividends.
    logic                  vr_reg;
    ssc_pkg::ctx_t         ctxr_reg;
    logic [DISTW-1:0]      denr_reg, denr_next, dist_rnd;
    logic [2:0][DISTW-1:0] remr_reg, remr_next;
    logic [2:0][QW-1:0]    numr_reg, numr_next;
    logic [NUMW-1:0]       num [3];

    always_comb
    begin
        dist_rnd = DISTW'(sroot[CW])
                 + DISTW'(srem[CW][REMW-1:0] > REMW'(sroot[CW]));
        denr_next = sctx[CW].hit ? dist_rnd : DISTW'(1);
        for (int k = 0; k < 3; k++)
        begin
            num[k] = {1'b0, sctx[CW].mag[k], {NFB{1'b0}}} + NUMW'(dist_rnd >> 1);
            remr_next[k] = DISTW'(num[k][NUMW-1:QW]);
            numr_next[k] = num[k][QW-1:0];
        end
    end

    // Divider: one cell per quotient bit.
    logic                  dv   [QW+1];
    ssc_pkg::ctx_t         dctx [QW+1];
    logic [DISTW-1:0]      dden [QW+1];
    logic [2:0][DISTW-1:0] drem [QW+1];
    logic [2:0][QW-1:0]    dnum [QW+1];
    logic [2:0][QW-1:0]    dq   [QW+1];

    assign dv[0]   = vr_reg;
    assign dctx[0] = ctxr_reg;
    assign dden[0] = denr_reg;
    assign drem[0] = remr_reg;
    assign dnum[0] = numr_reg;
    assign dq[0]   = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        ssc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .v_in    (dv[i]),
            .ctx_in  (dctx[i]),
            .den_in  (dden[i]),
            .rem_in  (drem[i]),
            .num_in  (dnum[i]),
            .q_in    (dq[i]),
            .v_out   (dv[i+1]),
            .ctx_out (dctx[i+1]),
            .den_out (dden[i+1]),
            .rem_out (drem[i+1]),
            .num_out (dnum[i+1]),
            .q_out   (dq[i+1])
        );
    end

    // Multiply stage: normal magnitude times each radius.
    logic                vm_reg;
    ssc_pkg::ctx_t       ctxm_reg;
    logic [DISTW-1:0]    denm_reg;
    logic [2:0][QW-1:0]  qm_reg;
    logic [2:0][PRW-1:0] pam_reg, pbm_reg, pam_next, pbm_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pam_next[k] = PRW'(dq[QW][k]) * PRW'(dctx[QW].ra);
            pbm_next[k] = PRW'(dq[QW][k]) * PRW'(dctx[QW].rb);
        end
    end

    // Finish: round offsets, add A's to its center and subtract B's from its center, saturate, and zero a miss.
    ssc_pkg::contact_t   fin;
    logic [PRW:0]        rsa, rsb;
    logic [OAW-1:0]      oam, obm;
    logic signed [EW-1:0] oa, ob, ca, cb, da [3], db [3];
    logic signed [NW-1:0] nq, nrm [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rsa = {1'b0, pam_reg[k]} + (PRW+1)'(1 << (NFB - 1));
            rsb = {1'b0, pbm_reg[k]} + (PRW+1)'(1 << (NFB - 1));
            oam = rsa[PRW:NFB];
            obm = rsb[PRW:NFB];
            oa  = ctxm_reg.dneg[k] ? -$signed(EW'(oam)) : $signed(EW'(oam));
            ob  = ctxm_reg.dneg[k] ? -$signed(EW'(obm)) : $signed(EW'(obm));
            ca  = $signed({{(EW-CENW){ctxm_reg.ac[k][CENW-1]}}, ctxm_reg.ac[k]});
            cb  = $signed({{(EW-CENW){ctxm_reg.bc[k][CENW-1]}}, ctxm_reg.bc[k]});
            da[k] = ca + oa;
            db[k] = cb - ob;
            nq = $signed(NW'(qm_reg[k]));
            nrm[k] = ctxm_reg.dneg[k] ? -nq : nq;
        end
        fin.hit         = ctxm_reg.hit;
        fin.deep_a_x    = ssc_pkg::sat_coord(da[0]);
        fin.deep_a_y    = ssc_pkg::sat_coord(da[1]);
        fin.deep_a_z    = ssc_pkg::sat_coord(da[2]);
        fin.deep_b_x    = ssc_pkg::sat_coord(db[0]);
        fin.deep_b_y    = ssc_pkg::sat_coord(db[1]);
        fin.deep_b_z    = ssc_pkg::sat_coord(db[2]);
        fin.normal_x    = nrm[0];
        fin.normal_y    = nrm[1];
        fin.normal_z    = nrm[2];
        fin.penetration = CW'(DISTW'(ctxm_reg.rsum) - denm_reg);
        if (!ctxm_reg.hit)
        begin
            fin = '0;
        end
    end

    // Output register plus skid slot.
    logic              push;
    logic              mv_reg, mv_next, skv_reg, skv_next;
    ssc_pkg::contact_t main_reg, main_next, skid_reg, skid_next;

    assign en   = !skv_reg;
    assign push = en && vm_reg;

    always_comb
    begin
        main_next = main_reg;
        mv_next   = mv_reg;
        skid_next = skid_reg;
        skv_next  = skv_reg;
        if (!mv_reg || contact.ready)
        begin
            if (skv_reg)
            begin
                main_next = skid_reg;
                mv_next   = 1'b1;
                skv_next  = 1'b0;
            end
            else
            begin
                main_next = fin;
                mv_next   = push;
            end
        end
        else if (push)
        begin
            skid_next = fin;
            skv_next  = 1'b1;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vr_reg  <= 1'b0;
            vm_reg  <= 1'b0;
            mv_reg  <= 1'b0;
            skv_reg <= 1'b0;
        end
        else
        begin
            mv_reg  <= mv_next;
            skv_reg <= skv_next;
            if (en)
            begin
                v1_reg <= pair.valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                vr_reg <= sv[CW];
                vm_reg <= dv[QW];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
        if (en)
        begin
            ac1_reg   <= ac1_next;
            bc1_reg   <= bc1_next;
            dneg1_reg <= dneg1_next;
            mag1_reg  <= mag1_next;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            ctx2_reg  <= ctx2_next;
            far2_reg  <= far2_next;
            ctx3_reg  <= ctx2_reg;
            far3_reg  <= far2_reg;
            sq3_reg   <= sq3_next;
            rsq3_reg  <= rsq3_next;
            ctx4_reg  <= ctx4_next;
            rad4_reg  <= rad4_next;
            ctxr_reg  <= sctx[CW];
            denr_reg  <= denr_next;
            remr_reg  <= remr_next;
            numr_reg  <= numr_next;
            ctxm_reg  <= dctx[QW];
            denm_reg  <= dden[QW];
            qm_reg    <= dq[QW];
            pam_reg   <= pam_next;
            pbm_reg   <= pbm_next;
        end
    end

    assign pair.ready    = en;
    assign contact.valid = mv_reg;
    assign contact.data  = main_reg;
endmodule
`default_nettype wire
